// ----- src/string_crc31_double_hash_index_macros.svh -----
// Assertion macros for the name hasher top level.
`ifndef STRING_CRC31_DOUBLE_HASH_INDEX_MACROS_SVH
`define STRING_CRC31_DOUBLE_HASH_INDEX_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCDHI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCDHI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/scdhi_pkg.sv -----
// Shared types, constants and the CRC table function of the name hasher.
package scdhi_pkg;

    // Field widths.
    localparam int FOLD_W = 31;
    localparam int SIZE_W = 16;
    localparam int BYTE_W = 8;
    localparam int IDX_W  = 7;
    localparam int CNT_W  = $clog2(FOLD_W);

    // Polynomial and reset values.
    localparam logic [FOLD_W-1:0] CRC_POLY      = 31'h4800_0000;
    localparam logic [SIZE_W-1:0] SIZE_RESET    = 16'd1021;
    localparam logic [SIZE_W-1:0] SIZE_MIN      = 16'd3;
    localparam logic [SIZE_W-1:0] SIZE_STEP_OFS = 16'd2;
    localparam logic [CNT_W-1:0]  CNT_LAST      = CNT_W'(FOLD_W - 1);

    // ASCII case folding.
    localparam logic [BYTE_W-1:0] ASCII_UPPER_A     = 8'h41;
    localparam logic [BYTE_W-1:0] ASCII_UPPER_Z     = 8'h5A;
    localparam logic [BYTE_W-1:0] ASCII_CASE_OFFSET = 8'h20;

    // Configuration register indexes.
    localparam logic CFG_TABLE_SIZE = 1'b0;
    localparam logic CFG_CASE_FOLD  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fold;   // a request is accepted: fold its byte
        logic load;   // the accepted byte ends a name: start the remainders
        logic step;   // one remainder bit step
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_bit;   // the current step handles the final dividend bit
    } t_dp_status;

    // One table entry: XOR of the polynomial shifted right by each set index bit.
    function automatic logic [FOLD_W-1:0] crc_entry(input logic [IDX_W-1:0] idx);
        logic [FOLD_W-1:0] acc;
        acc = '0;
        for (int j = 0; j < IDX_W; j++) begin
            if (idx[j]) begin
                acc = acc ^ (CRC_POLY >> j);
            end
        end
        return acc;
    endfunction

endpackage

// ----- src/scdhi_ctrl.sv -----
// Controller of the name hasher: handshakes and the remainder sequence.
module scdhi_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_last_byte,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  scdhi_pkg::t_dp_status i_status,
    output scdhi_pkg::t_dp_cmd    o_cmd
);
    import scdhi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   back_free;
    logic   accept;

    // The back end can take a new name once its result is gone or leaving.
    assign back_free = (r_state == S_IDLE) || ((r_state == S_OUT) && i_out_ready);

    // Middle bytes always pass; a last byte waits for a free back end.
    assign o_in_ready  = !i_last_byte || back_free;
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);

    assign o_cmd.fold = accept;
    assign o_cmd.load = accept && i_last_byte;
    assign o_cmd.step = (r_state == S_DIV);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_status.last_bit) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (o_cmd.load) begin
                    n_state = S_DIV;
                end else if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- src/scdhi_datapath.sv -----
// Datapath of the name hasher: byte folding, configuration and two remainders.
module scdhi_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [scdhi_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic [scdhi_pkg::BYTE_W-1:0]  i_name_byte,
    input  scdhi_pkg::t_dp_cmd            i_cmd,
    output scdhi_pkg::t_dp_status         o_status,
    output logic [scdhi_pkg::FOLD_W-1:0]  o_fold_value,
    output logic [scdhi_pkg::SIZE_W-1:0]  o_home_slot,
    output logic [scdhi_pkg::SIZE_W-1:0]  o_probe_step
);
    import scdhi_pkg::*;

    logic [SIZE_W-1:0] r_table_size;
    logic              r_case_fold;
    logic [FOLD_W-1:0] r_fold;
    logic [FOLD_W-1:0] r_value;
    logic [FOLD_W-1:0] r_shift;
    logic [SIZE_W-1:0] r_div_a;
    logic [SIZE_W-1:0] r_div_b;
    logic [SIZE_W-1:0] r_rem_a;
    logic [SIZE_W-1:0] r_rem_b;
    logic [CNT_W-1:0]  r_cnt;

    logic [BYTE_W-1:0] char_in;
    logic [FOLD_W-1:0] n_fold;
    logic [SIZE_W-1:0] size_eff;
    logic [SIZE_W:0]   trial_a;
    logic [SIZE_W:0]   trial_b;
    logic [SIZE_W:0]   diff_a;
    logic [SIZE_W:0]   diff_b;
    logic [SIZE_W-1:0] n_rem_a;
    logic [SIZE_W-1:0] n_rem_b;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
            r_case_fold  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                CFG_CASE_FOLD:  r_case_fold  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Optional lowering of ASCII uppercase letters.
    always_comb begin
        char_in = i_name_byte;
        if (r_case_fold && (i_name_byte >= ASCII_UPPER_A) && (i_name_byte <= ASCII_UPPER_Z)) begin
            char_in = i_name_byte + ASCII_CASE_OFFSET;
        end
    end

    // Seven bits of the running value per byte through the CRC table.
    assign n_fold = (r_fold >> IDX_W) ^ crc_entry(r_fold[IDX_W-1:0] ^ char_in[IDX_W-1:0]);

    // The running value starts over after the last byte of a name.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= '0;
        end else if (i_cmd.fold) begin
            r_fold <= i_cmd.load ? '0 : n_fold;
        end
    end

    // Sizes below the minimum are treated as the minimum.
    assign size_eff = (r_table_size < SIZE_MIN) ? SIZE_MIN : r_table_size;

    // Restoring division, one dividend bit per step, for both divisors at once.
    assign trial_a = {r_rem_a, r_shift[FOLD_W-1]};
    assign trial_b = {r_rem_b, r_shift[FOLD_W-1]};
    assign diff_a  = trial_a - {1'b0, r_div_a};
    assign diff_b  = trial_b - {1'b0, r_div_b};
    assign n_rem_a = (trial_a >= {1'b0, r_div_a}) ? diff_a[SIZE_W-1:0] : trial_a[SIZE_W-1:0];
    assign n_rem_b = (trial_b >= {1'b0, r_div_b}) ? diff_b[SIZE_W-1:0] : trial_b[SIZE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= n_fold;
            r_shift <= n_fold;
            r_div_a <= size_eff;
            r_div_b <= size_eff - SIZE_STEP_OFS;
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_cnt   <= '0;
        end else if (i_cmd.step) begin
            r_shift <= {r_shift[FOLD_W-2:0], 1'b0};
            r_rem_a <= n_rem_a;
            r_rem_b <= n_rem_b;
            r_cnt   <= r_cnt + 1'b1;
        end
    end

    assign o_status.last_bit = (r_cnt == CNT_LAST);

    // Result fields, held stable until the result is taken.
    assign o_fold_value = r_value;
    assign o_home_slot  = r_rem_a;
    assign o_probe_step = r_div_b - r_rem_b;

endmodule

// ----- src/string_crc31_double_hash_index.sv -----
// Top level of the streaming name hasher with double-hashing index.
// Takes a name one byte per request, with last_byte set on its final character,
// and folds each byte into a 31-bit CRC (polynomial 0x48000000, seven bits per
// byte) in the cycle it is accepted, so name bytes flow at one per cycle. The
// last byte starts a bit-serial divider that forms value mod size and
// value mod (size - 2) together, one dividend bit per cycle: the result request
// (fold value, home slot, probe step) follows the final dividend bit.
// Middle bytes of the next name keep flowing meanwhile; its last byte
// is held off until the pending result is taken. Configuration registers:
// index 0 is the table size (values below 3 act as 3), index 1 enables ASCII
// case folding; write them only while no name is in progress.
`include "string_crc31_double_hash_index_macros.svh"

module string_crc31_double_hash_index (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [scdhi_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [scdhi_pkg::BYTE_W-1:0]  i_name_byte,
    input  logic                          i_last_byte,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [scdhi_pkg::FOLD_W-1:0]  o_fold_value,
    output logic [scdhi_pkg::SIZE_W-1:0]  o_home_slot,
    output logic [scdhi_pkg::SIZE_W-1:0]  o_probe_step
);
    import scdhi_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Handshake and sequencing control.
    scdhi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_byte (i_last_byte),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Folding, configuration and remainder datapath.
    scdhi_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_name_byte  (i_name_byte),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_fold_value (o_fold_value),
        .o_home_slot  (o_home_slot),
        .o_probe_step (o_probe_step)
    );

    // A new name end always starts the divider in the next cycle.
    `SCDHI_ASSERT_NEXT(a_load_starts_div, i_clk, i_rst_n, cmd.load, cmd.step, "divider did not start after a name end")

    // The final divider step always presents a result.
    `SCDHI_ASSERT_NEXT(a_div_ends_in_result, i_clk, i_rst_n, cmd.step && status.last_bit, o_out_valid, "no result after the final divider step")

    // A presented result is never disturbed by divider steps.
    `SCDHI_ASSERT_SAME(a_no_step_while_out, i_clk, i_rst_n, o_out_valid, !cmd.step, "divider stepping while a result is pending")

endmodule
